@@ hw/rtl/hdp_pkg.sv @@
// types and constants shared by the header directive parser
// no dependencies; imported by every module of the block
package hdp_pkg;

  // configuration register file
  localparam int unsigned CfgW  = 12;
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  localparam logic [CfgW-1:0] NameMaxReset    = 12'd128;
  localparam logic [CfgW-1:0] CommentMaxReset = 12'd2048;

  // register indexes (word address bit 2)
  localparam logic RegIdxNameMax    = 1'b0;
  localparam logic RegIdxCommentMax = 1'b1;

  // characters of interest
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChSemi    = 8'h3B;
  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChNewline = 8'h0A;

  // accepted directive names, first character in the top byte
  localparam int unsigned NameWordLen    = 4;
  localparam int unsigned CommentWordLen = 7;
  localparam logic [8*NameWordLen-1:0]    NameWord    = "name";
  localparam logic [8*CommentWordLen-1:0] CommentWord = "comment";

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_NAME,
    PH_QUOTE,
    PH_VALUE,
    PH_AFTER,
    PH_REMARK,
    PH_ERROR
  } phase_e;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_BYTE = 2'd1,
    EV_DONE = 2'd2,
    EV_ERR  = 2'd3
  } ev_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE          = 3'd0,
    ERR_NO_QUOTE      = 3'd1,
    ERR_TOO_LONG      = 3'd2,
    ERR_BAD_DIRECTIVE = 3'd3,
    ERR_JUNK_AFTER    = 3'd4,
    ERR_TOO_MANY      = 3'd5
  } err_code_e;

  typedef struct packed {
    logic [7:0] source_char;
    logic       starts_directive;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      event_kind;
    logic            which_value;
    logic [CfgW-1:0] value_position;
    logic [7:0]      value_byte;
    logic [2:0]      error_code;
    logic            header_complete;
  } out_item_t;

endpackage

@@ hw/rtl/hdp_cfg_regs.sv @@
// value length limit registers behind the apb-style port
// depends on hdp_pkg
module hdp_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hdp_pkg::AddrW-1:0]  paddr,
  input  logic [hdp_pkg::DataW-1:0]  pwdata,
  output logic [hdp_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output logic [hdp_pkg::CfgW-1:0]   name_max_o,
  output logic [hdp_pkg::CfgW-1:0]   comment_max_o
);
  import hdp_pkg::*;

  logic [CfgW-1:0] name_max_q, name_max_d;
  logic [CfgW-1:0] comment_max_q, comment_max_d;
  logic            wr_en;
  logic            reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[2];

  // write decode, word aligned
  always_comb begin
    name_max_d    = name_max_q;
    comment_max_d = comment_max_q;
    if (wr_en) begin
      unique case (reg_idx)
        RegIdxNameMax:    name_max_d    = pwdata[CfgW-1:0];
        RegIdxCommentMax: comment_max_d = pwdata[CfgW-1:0];
        default:          name_max_d    = name_max_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_max_q    <= NameMaxReset;
      comment_max_q <= CommentMaxReset;
    end else begin
      name_max_q    <= name_max_d;
      comment_max_q <= comment_max_d;
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      RegIdxNameMax:    prdata = {{(DataW-CfgW){1'b0}}, name_max_q};
      RegIdxCommentMax: prdata = {{(DataW-CfgW){1'b0}}, comment_max_q};
      default:          prdata = '0;
    endcase
  end

  assign name_max_o    = name_max_q;
  assign comment_max_o = comment_max_q;

endmodule

@@ hw/rtl/hdp_step.sv @@
// parse phase machine and directive state, one character per fire
// depends on hdp_pkg
module hdp_step #(
  parameter int unsigned NAME_BUFFER_LEN  = 8,
  parameter int unsigned MAX_VALUE_LENGTH = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fire_i,
  input  hdp_pkg::in_item_t         item_i,
  input  logic [hdp_pkg::CfgW-1:0]  name_max_i,
  input  logic [hdp_pkg::CfgW-1:0]  comment_max_i,
  output hdp_pkg::out_item_t        result_o
);
  import hdp_pkg::*;

  localparam int unsigned LenW   = $clog2(NAME_BUFFER_LEN);
  localparam int unsigned CfgMax = (1 << CfgW) - 1;
  localparam logic [CfgW-1:0] LimCap =
    CfgW'((MAX_VALUE_LENGTH > CfgMax) ? CfgMax : MAX_VALUE_LENGTH);

  phase_e          phase_q, phase_d;
  logic [LenW-1:0] len_q, len_d;
  logic [7:0]      buf_q [NAME_BUFFER_LEN];
  logic            cur_q, cur_d;
  logic [CfgW-1:0] cnt_q, cnt_d;
  logic [1:0]      dir_q, dir_d;
  logic            name_ne_q, name_ne_d;
  logic            com_ne_q, com_ne_d;

  logic [7:0]      c;
  logic            flag;
  logic            is_blank, is_quote, is_remark, is_nl;
  logic            start_new, too_many, in_name, name_full;
  logic [LenW-1:0] eff_len;
  logic            buf_we;
  logic            match_name, match_comment, name_bad;
  logic [CfgW-1:0] lim_raw, lim;
  logic            over_lim;

  assign c         = item_i.source_char;
  assign flag      = item_i.starts_directive;
  assign is_blank  = (c == ChSpace) || (c == ChTab);
  assign is_quote  = (c == ChQuote);
  assign is_remark = (c == ChSemi) || (c == ChHash);
  assign is_nl     = (c == ChNewline);

  // directive start and name handling
  assign start_new = (phase_q == PH_IDLE) && flag && (dir_q < 2'd2);
  assign too_many  = (phase_q == PH_IDLE) && flag && !(dir_q < 2'd2);
  assign in_name   = (phase_q == PH_NAME) || start_new;
  assign eff_len   = start_new ? '0 : len_q;
  assign name_full = eff_len >= LenW'(NAME_BUFFER_LEN - 1);

  // compare held name against the two accepted words
  always_comb begin
    match_name    = (phase_q == PH_NAME) && (len_q == LenW'(NameWordLen));
    match_comment = (phase_q == PH_NAME) && (len_q == LenW'(CommentWordLen));
    for (int i = 0; i < NameWordLen; i++) begin
      if (buf_q[i] != NameWord[8*(NameWordLen-1-i) +: 8]) match_name = 1'b0;
    end
    for (int i = 0; i < CommentWordLen; i++) begin
      if (buf_q[i] != CommentWord[8*(CommentWordLen-1-i) +: 8]) match_comment = 1'b0;
    end
  end

  assign name_bad = is_blank ? !(match_name || match_comment) : name_full;

  // value length limit
  assign lim_raw  = cur_q ? comment_max_i : name_max_i;
  assign lim      = (lim_raw > LimCap) ? LimCap : lim_raw;
  assign over_lim = cnt_q >= lim;

  // next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_IDLE: begin
        if (too_many) begin
          phase_d = PH_ERROR;
        end else if (start_new) begin
          phase_d = name_bad ? PH_ERROR : (is_blank ? PH_QUOTE : PH_NAME);
        end
      end
      PH_NAME: begin
        phase_d = name_bad ? PH_ERROR : (is_blank ? PH_QUOTE : PH_NAME);
      end
      PH_QUOTE: begin
        if (is_quote) phase_d = PH_VALUE;
        else if (!is_blank) phase_d = PH_ERROR;
      end
      PH_VALUE: begin
        if (is_quote) phase_d = PH_AFTER;
        else if (over_lim) phase_d = PH_ERROR;
      end
      PH_AFTER: begin
        if (is_remark) phase_d = PH_REMARK;
        else if (is_nl) phase_d = PH_IDLE;
        else if (!is_blank) phase_d = PH_ERROR;
      end
      PH_REMARK: begin
        if (is_nl) phase_d = PH_IDLE;
      end
      PH_ERROR: phase_d = PH_ERROR;
      default:  phase_d = PH_ERROR;
    endcase
  end

  // directive state updates
  always_comb begin
    len_d     = len_q;
    cur_d     = cur_q;
    cnt_d     = cnt_q;
    dir_d     = dir_q;
    name_ne_d = name_ne_q;
    com_ne_d  = com_ne_q;
    buf_we    = 1'b0;
    if (start_new) begin
      dir_d = dir_q + 2'd1;
      len_d = '0;
    end
    if (in_name && !is_blank && !name_full) begin
      buf_we = 1'b1;
      len_d  = eff_len + LenW'(1);
    end
    if (in_name && is_blank) begin
      if (match_name) cur_d = 1'b0;
      else if (match_comment) cur_d = 1'b1;
    end
    if ((phase_q == PH_QUOTE) && is_quote) cnt_d = '0;
    if ((phase_q == PH_VALUE) && !is_quote && !over_lim) begin
      cnt_d = cnt_q + CfgW'(1);
      if (cnt_q == '0) begin
        if (cur_q) com_ne_d = (c != 8'h00);
        else name_ne_d = (c != 8'h00);
      end
    end
  end

  // result of this character
  always_comb begin
    result_o = '0;
    unique case (phase_q)
      PH_IDLE, PH_NAME: begin
        if (too_many) begin
          result_o.event_kind = EV_ERR;
          result_o.error_code = ERR_TOO_MANY;
        end else if (in_name && name_bad) begin
          result_o.event_kind = EV_ERR;
          result_o.error_code = ERR_BAD_DIRECTIVE;
        end
      end
      PH_QUOTE: begin
        if (!is_blank && !is_quote) begin
          result_o.event_kind  = EV_ERR;
          result_o.which_value = cur_q;
          result_o.error_code  = ERR_NO_QUOTE;
        end
      end
      PH_VALUE: begin
        if (!is_quote) begin
          result_o.which_value = cur_q;
          if (over_lim) begin
            result_o.event_kind = EV_ERR;
            result_o.error_code = ERR_TOO_LONG;
          end else begin
            result_o.event_kind     = EV_BYTE;
            result_o.value_position = cnt_q;
            result_o.value_byte     = c;
          end
        end
      end
      PH_AFTER: begin
        if (!is_blank && !is_remark) begin
          result_o.which_value = cur_q;
          if (is_nl) begin
            result_o.event_kind      = EV_DONE;
            result_o.header_complete = name_ne_q & com_ne_q;
          end else begin
            result_o.event_kind = EV_ERR;
            result_o.error_code = ERR_JUNK_AFTER;
          end
        end
      end
      PH_REMARK: begin
        if (is_nl) begin
          result_o.event_kind      = EV_DONE;
          result_o.which_value     = cur_q;
          result_o.header_complete = name_ne_q & com_ne_q;
        end
      end
      default: result_o = '0;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      len_q     <= '0;
      cur_q     <= 1'b0;
      cnt_q     <= '0;
      dir_q     <= 2'd0;
      name_ne_q <= 1'b0;
      com_ne_q  <= 1'b0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      len_q     <= len_d;
      cur_q     <= cur_d;
      cnt_q     <= cnt_d;
      dir_q     <= dir_d;
      name_ne_q <= name_ne_d;
      com_ne_q  <= com_ne_d;
    end
  end

  // name buffer, no reset
  always_ff @(posedge clk_i) begin
    if (fire_i && buf_we) begin
      buf_q[eff_len] <= c;
    end
  end

  // checks
  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_ERROR |=> phase_q == PH_ERROR)
    else $error("error phase left before reset");

  a_dir_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dir_q != 2'd3)
    else $error("directive count overran");

  a_byte_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (result_o.event_kind == EV_BYTE) |-> result_o.value_position < lim)
    else $error("value byte beyond length limit");

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (result_o.event_kind == EV_DONE) |=> phase_q == PH_IDLE)
    else $error("finished directive did not return to idle");

endmodule

@@ hw/rtl/header_directive_parser_unit.sv @@
// header directive parser: input register, phase machine, result register
// an accepted transfer is held in the input register, and its result then in the result register
// throughput: one character per cycle, no bubbles while the output is not stalled
// reset: asynchronous, active low; limits return to 128 and 2048, parser to idle
// errors are sticky until reset; depends on hdp_pkg, hdp_cfg_regs, hdp_step
module header_directive_parser_unit #(
  parameter int unsigned NAME_BUFFER_LEN  = 8,
  parameter int unsigned MAX_VALUE_LENGTH = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  hdp_pkg::in_item_t          in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output hdp_pkg::out_item_t         out_item_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hdp_pkg::AddrW-1:0]  paddr,
  input  logic [hdp_pkg::DataW-1:0]  pwdata,
  output logic [hdp_pkg::DataW-1:0]  prdata,
  output logic                       pready
);
  import hdp_pkg::*;

  logic            in_vld_q;
  in_item_t        in_item_q;
  logic            out_vld_q;
  out_item_t       out_item_q;
  out_item_t       step_res;
  logic            advance, accept, fire;
  logic [CfgW-1:0] name_max, comment_max;

  hdp_cfg_regs u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .name_max_o    (name_max),
    .comment_max_o (comment_max)
  );

  // pipeline handshake
  assign advance    = !out_vld_q || !out_stall_i;
  assign in_stall_o = in_vld_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign fire       = in_vld_q && advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_vld_q || advance) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_item_q <= in_item_i;
    end
  end

  hdp_step #(
    .NAME_BUFFER_LEN  (NAME_BUFFER_LEN),
    .MAX_VALUE_LENGTH (MAX_VALUE_LENGTH)
  ) u_step (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .item_i        (in_item_q),
    .name_max_i    (name_max),
    .comment_max_i (comment_max),
    .result_o      (step_res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_item_q <= step_res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_item_q;

endmodule

@@ verif/tb_header_directive_parser_unit.sv @@
// self-checking testbench for header_directive_parser_unit
// depends on hdp_pkg and the rtl top level; queue-fed driver, checking monitor
`timescale 1ns / 100ps

module tb_header_directive_parser_unit;
  import hdp_pkg::*;

  localparam int unsigned NameBufLen  = 8;
  localparam int unsigned QuietLimit  = 3000;
  localparam int unsigned HoldoffLen  = 240;
  localparam int unsigned HoldoffMark = 300;
  localparam int unsigned IdlePct     = 28;

  typedef enum int {
    END_THIRD,
    END_NO_QUOTE,
    END_TOO_LONG,
    END_BAD_NAME,
    END_JUNK
  } ending_e;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // block ports
  logic                in_valid    = 1'b0;
  logic                in_stall_o;
  in_item_t            in_item     = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_item_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [AddrW-1:0]    paddr       = '0;
  logic [DataW-1:0]    pwdata      = '0;
  logic [DataW-1:0]    prdata;
  logic                pready;

  header_directive_parser_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // pending characters and expected events
  in_item_t  pending_chars[$];
  out_item_t expected_events[$];
  int unsigned items_pushed  = 0;
  int unsigned inputs_taken  = 0;
  int unsigned results_seen  = 0;
  int unsigned failures      = 0;
  int unsigned cycles        = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned holdoff_left  = 0;
  logic        holdoff_done  = 1'b0;

  // stretch of the run with no idling on either side
  wire calm = (cycles >= 1200) && (cycles < 1700);

  // parser state as predicted
  phase_e          parser_phase    = PH_IDLE;
  logic [7:0]      dir_word [NameBufLen];
  int unsigned     dir_word_len    = 0;
  logic            active_value    = 1'b0;
  int unsigned     value_len       = 0;
  int unsigned     directives_seen = 0;
  logic            name_set        = 1'b0;
  logic            comment_set     = 1'b0;
  logic [CfgW-1:0] name_limit      = NameMaxReset;
  logic [CfgW-1:0] comment_limit   = CommentMaxReset;

  function automatic void flag_mismatch(input string msg);
    failures++;
    if (failures <= 10) $display("MISMATCH: %s", msg);
  endfunction

  function automatic string describe(input out_item_t e);
    return $sformatf("kind %0d which %0d pos %0d byte %02h err %0d complete %0b",
                     e.event_kind, e.which_value, e.value_position, e.value_byte,
                     e.error_code, e.header_complete);
  endfunction

  function automatic logic word_matches(input logic [8*CommentWordLen-1:0] word,
                                        input int unsigned len);
    if (dir_word_len != len) return 1'b0;
    for (int i = 0; i < len; i++) begin
      if (dir_word[i] != word[8*(len-1-i) +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic out_item_t fail_with(input err_code_e code, input logic which);
    out_item_t r;
    r = '0;
    parser_phase = PH_ERROR;
    r.event_kind = EV_ERR;
    r.which_value = which;
    r.error_code = code;
    return r;
  endfunction

  function automatic out_item_t finish_directive();
    out_item_t r;
    r = '0;
    parser_phase = PH_IDLE;
    r.event_kind = EV_DONE;
    r.which_value = active_value;
    r.header_complete = name_set && comment_set;
    return r;
  endfunction

  // one character through the phase machine, returns the event it causes
  function automatic out_item_t parse_char(input in_item_t item);
    out_item_t       r;
    logic [7:0]      c;
    logic            blank;
    logic [CfgW-1:0] lim;
    r = '0;
    c = item.source_char;
    blank = (c == ChSpace) || (c == ChTab);
    if (parser_phase == PH_IDLE) begin
      if (!item.starts_directive) return r;
      if (directives_seen >= 2) return fail_with(ERR_TOO_MANY, 1'b0);
      directives_seen++;
      dir_word_len = 0;
      parser_phase = PH_NAME;
    end
    case (parser_phase)
      PH_NAME: begin
        if (blank) begin
          if (word_matches((8*CommentWordLen)'(NameWord), NameWordLen)) active_value = 1'b0;
          else if (word_matches(CommentWord, CommentWordLen)) active_value = 1'b1;
          else return fail_with(ERR_BAD_DIRECTIVE, 1'b0);
          parser_phase = PH_QUOTE;
        end else if (dir_word_len >= NameBufLen - 1) begin
          return fail_with(ERR_BAD_DIRECTIVE, 1'b0);
        end else begin
          dir_word[dir_word_len] = c;
          dir_word_len++;
        end
      end
      PH_QUOTE: begin
        if (!blank) begin
          if (c != ChQuote) return fail_with(ERR_NO_QUOTE, active_value);
          value_len = 0;
          parser_phase = PH_VALUE;
        end
      end
      PH_VALUE: begin
        lim = active_value ? comment_limit : name_limit;
        if (c == ChQuote) begin
          parser_phase = PH_AFTER;
        end else if (value_len >= lim) begin
          return fail_with(ERR_TOO_LONG, active_value);
        end else begin
          // first byte decides whether the value counts as present
          if (value_len == 0) begin
            if (active_value) comment_set = (c != 8'h00);
            else name_set = (c != 8'h00);
          end
          r.event_kind = EV_BYTE;
          r.which_value = active_value;
          r.value_position = value_len[CfgW-1:0];
          r.value_byte = c;
          value_len++;
        end
      end
      PH_AFTER: begin
        if (c == ChSemi || c == ChHash) parser_phase = PH_REMARK;
        else if (c == ChNewline) return finish_directive();
        else if (!blank) return fail_with(ERR_JUNK_AFTER, active_value);
      end
      PH_REMARK: begin
        if (c == ChNewline) return finish_directive();
      end
      default: ;
    endcase
    return r;
  endfunction

  // driver: offers queued characters, predicts each accepted transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        expected_events.push_back(parse_char(in_item));
        inputs_taken <= inputs_taken + 1;
      end
      if (!in_valid || !in_stall_o) begin
        if (pending_chars.size() != 0 && (calm || $urandom_range(0, 99) >= IdlePct)) begin
          in_item  <= pending_chars.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transfer, drives the output stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen <= results_seen + 1;
        if (expected_events.size() == 0) begin
          flag_mismatch($sformatf("unexpected result: %s", describe(out_item_o)));
        end else if (out_item_o !== expected_events[0]) begin
          flag_mismatch($sformatf("result %0d expected %s got %s", results_seen,
                                  describe(expected_events.pop_front()),
                                  describe(out_item_o)));
        end else begin
          void'(expected_events.pop_front());
        end
      end
      // one long hold-off so the block fills and stalls its input
      if (holdoff_left != 0) begin
        holdoff_left <= holdoff_left - 1;
        out_stall_i  <= 1'b1;
      end else if (!holdoff_done && results_seen >= HoldoffMark) begin
        holdoff_done <= 1'b1;
        holdoff_left <= HoldoffLen;
        out_stall_i  <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(0, 99) < IdlePct);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // register access, setup then access cycle
  task automatic apb_cycle(input logic wr, input logic idx, input logic [DataW-1:0] wdata,
                           output logic [DataW-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_reg(input logic idx, input logic [CfgW-1:0] want);
    logic [DataW-1:0] got;
    apb_cycle(1'b0, idx, '0, got);
    if (got !== DataW'(want))
      flag_mismatch($sformatf("register %0d expected %0d got %0d", idx, want, got));
  endtask

  task automatic set_limit(input logic idx, input logic [CfgW-1:0] val);
    logic [DataW-1:0] unused;
    apb_cycle(1'b1, idx, DataW'(val), unused);
    if (idx == RegIdxCommentMax) comment_limit = val;
    else name_limit = val;
    check_reg(idx, val);
  endtask

  task automatic wait_drained();
    while (results_seen < items_pushed) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // stimulus builders
  function automatic void put(input logic [7:0] c, input logic f);
    in_item_t item;
    item.source_char = c;
    item.starts_directive = f;
    pending_chars.push_back(item);
    items_pushed++;
  endfunction

  function automatic logic inner_flag();
    return $urandom_range(0, 3) == 0;
  endfunction

  function automatic logic [7:0] any_blank();
    return $urandom_range(0, 1) ? ChSpace : ChTab;
  endfunction

  function automatic void put_noise(input int unsigned n);
    for (int i = 0; i < n; i++) put(8'($urandom_range(0, 255)), 1'b0);
  endfunction

  // directive word with the flag on its first byte, then blanks and the quote
  function automatic void put_opening(input logic kind);
    string w;
    if (kind) w = "comment";
    else w = "name";
    for (int i = 0; i < w.len(); i++) put(w[i], (i == 0) ? 1'b1 : inner_flag());
    repeat ($urandom_range(1, 3)) put(any_blank(), inner_flag());
    put(ChQuote, inner_flag());
  endfunction

  function automatic void put_value(input int unsigned len, input logic zero_first);
    logic [7:0] c;
    for (int i = 0; i < len; i++) begin
      do c = 8'($urandom_range(0, 255)); while (c == ChQuote);
      if (i == 0 && zero_first) c = 8'h00;
      put(c, inner_flag());
    end
  endfunction

  function automatic void put_directive(input logic kind, input int unsigned len,
                                        input logic zero_first);
    logic [7:0] c;
    put_opening(kind);
    put_value(len, zero_first);
    put(ChQuote, inner_flag());
    repeat ($urandom_range(0, 3)) put(any_blank(), inner_flag());
    if ($urandom_range(0, 1)) begin
      put($urandom_range(0, 1) ? ChSemi : ChHash, inner_flag());
      repeat ($urandom_range(0, 10)) begin
        do c = 8'($urandom_range(0, 255)); while (c == ChNewline);
        put(c, inner_flag());
      end
    end
    put(ChNewline, inner_flag());
  endfunction

  initial begin : stimulus
    ending_e     ending;
    logic        first_kind;
    logic        empty_second;
    logic        first_idx;
    logic        second_idx;
    int unsigned len1;
    int unsigned len2;
    logic [7:0]  c;
    string       bad_words [5];
    bad_words = '{"nam", "names", "NAME", "commen", "comments"};
    ending = ending_e'($urandom_range(0, 4));
    first_kind = 1'($urandom_range(0, 1));
    first_idx = first_kind ? RegIdxCommentMax : RegIdxNameMax;
    second_idx = first_kind ? RegIdxNameMax : RegIdxCommentMax;
    empty_second = (ending == END_THIRD) && ($urandom_range(0, 2) == 0);
    if (ending == END_NO_QUOTE || ending == END_BAD_NAME || empty_second) begin
      len1 = $urandom_range(1750, 1900);
      len2 = 0;
    end else begin
      len1 = $urandom_range(850, 1000);
      len2 = $urandom_range(850, 1000);
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_reg(RegIdxNameMax, NameMaxReset);
    check_reg(RegIdxCommentMax, CommentMaxReset);

    // first directive with its value exactly at the limit
    set_limit(first_idx, CfgW'(len1));
    put(8'h00, 1'b0);
    put(8'hFF, 1'b0);
    put(ChQuote, 1'b0);
    put(ChNewline, 1'b0);
    put(ChSpace, 1'b0);
    put_directive(first_kind, len1, $urandom_range(0, 3) == 0);
    wait_drained();

    // second directive, ending in the chosen way
    set_limit(first_idx, '0);
    set_limit(second_idx, (ending == END_TOO_LONG) ? CfgW'(len2 - 1) : '1);
    put_noise($urandom_range(3, 10));
    case (ending)
      END_THIRD: begin
        put_directive(!first_kind, len2, $urandom_range(0, 3) == 0);
        put_noise($urandom_range(0, 6));
        put(8'($urandom_range(0, 255)), 1'b1);
      end
      END_NO_QUOTE: begin
        put_opening(!first_kind);
        void'(pending_chars.pop_back());
        items_pushed--;
        do c = 8'($urandom_range(0, 255));
        while (c == ChSpace || c == ChTab || c == ChQuote);
        put(c, inner_flag());
      end
      END_TOO_LONG: begin
        put_opening(!first_kind);
        put_value(len2, 1'b0);
      end
      END_BAD_NAME: begin
        if ($urandom_range(0, 5) == 0) begin
          put(any_blank(), 1'b1);
        end else begin
          bad_words.shuffle();
          for (int i = 0; i < bad_words[0].len(); i++)
            put(bad_words[0][i], (i == 0) ? 1'b1 : inner_flag());
          put(any_blank(), inner_flag());
        end
      end
      default: begin
        put_opening(!first_kind);
        put_value(len2, 1'b0);
        put(ChQuote, inner_flag());
        repeat ($urandom_range(0, 3)) put(any_blank(), inner_flag());
        do c = 8'($urandom_range(0, 255));
        while (c == ChSpace || c == ChTab || c == ChSemi || c == ChHash || c == ChNewline);
        put(c, inner_flag());
      end
    endcase
    wait_drained();

    // limits at the extremes, then bytes that must all be ignored
    set_limit(RegIdxNameMax, '1);
    set_limit(RegIdxCommentMax, '0);
    for (int i = 0; i < 40; i++) put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    wait_drained();
    if (expected_events.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", expected_events.size()));

    $display("Covered %0d characters and %0d results: %s directive first, ending %s",
             inputs_taken, results_seen, first_kind ? "comment" : "name", ending.name());
    $display("Value lengths %0d and %0d, limits swept between 0 and 4095", len1, len2);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
